// ----- hdl/i2cm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2cm_pkg
// Command codes, field widths and the packed result type shared by the
// I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// command codes carried in the opcode field
	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_START = 3'd1;
	localparam logic [2:0] OP_STOP  = 3'd2;
	localparam logic [2:0] OP_WRITE = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;
	localparam logic [2:0] OP_RACK  = 3'd5;

	localparam int unsigned BYTE_BITS = 8;
	localparam logic [7:0]  MSB_MASK  = 8'h80;
	localparam logic [7:0]  PHASE_RST = 8'd4;

	// one result item, lowest field last so that the packing matches tdata
	typedef struct packed {
		logic       ack_bit;
		logic [7:0] rx_byte;
		logic       cmd_done;
		logic       busy_res;
		logic       sda_is_input;
		logic       sda_level;
		logic       scl_level;
	} result_t;

endpackage
`default_nettype wire

// ----- hdl/i2c_master_byte_engine_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_core
// Pin-level I2C master sequencer: one input transfer per bus timing tick.
// ----------------------------------------------------------------------------
// Usage
// - s_* channel: one transfer per tick. tuser holds the command code
//   (0 none, 1 start, 2 stop, 3 write, 4 read, 5 read ack), tdata holds the
//   byte to write, the ack to send after a read and the sampled SDA level.
//   A command arriving while a previous one is still running is ignored.
// - m_* channel: one result transfer per input transfer, carrying the SCL and
//   SDA pin levels, SDA direction, busy, the done pulse, the last received
//   byte and the last sampled ack.
// - cfg_* channel: writes phase_ticks, the ticks between sequencer steps (0 acts
//   as 1). Always ready; write it only while the engine is idle.
// An input transfer passes through the input register, then the sequencer step
// and the result register. One tick is taken per clock while m_tready does not
// stall; the rate is set by the single step of sequencer logic per tick.
// A stalled m_tready holds the result register and, once the input register
// is also full, drops s_tready; no transfer is lost.
// Reset (arst_n low) returns the engine to idle with SCL and SDA released
// and phase_ticks at 4.
// ----------------------------------------------------------------------------
module i2c_master_byte_engine_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input ticks
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // write_data[7:0], send_ack[8], sda_in[9], zero
	input  wire logic [2:0]  s_tuser,  // opcode[2:0]
	// results
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,  // scl_level[0], sda_level[1], sda_is_input[2],
	                                   // busy_res[3], cmd_done[4], rx_byte[12:5],
	                                   // ack_bit[13], zero
	// configuration
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_data
);

	// input register stage
	logic       valid_s1;
	logic [2:0] opcode_s1;
	logic [7:0] wdata_s1;
	logic       send_ack_s1;
	logic       sda_in_s1;

	// sequencer state
	logic [7:0] phase_q;
	logic [2:0] active_op_q;
	logic [3:0] step_q;
	logic [7:0] tick_q;
	logic [3:0] bit_q;
	logic [7:0] shift_q;
	logic       scl_q;
	logic       sda_q;
	logic       dir_q;
	logic       ack_q;
	logic [7:0] rx_q;
	logic       ack_send_q;

	// result register
	logic                 out_valid_q;
	i2cm_pkg::result_t    out_q;

	// next-state values
	logic       advance;
	logic       execute;
	logic       done;
	logic [2:0] active_op_d;
	logic [3:0] step_d;
	logic [7:0] tick_d;
	logic [3:0] bit_d;
	logic [7:0] shift_d;
	logic       scl_d;
	logic       sda_d;
	logic       dir_d;
	logic       ack_d;
	logic [7:0] rx_d;
	logic       ack_send_d;
	logic [3:0] bit_inc;
	logic [3:0] step_cur;

	// handshakes
	assign advance   = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = {2'b00, out_q};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			opcode_s1   <= s_tuser;
			wdata_s1    <= s_tdata[7:0];
			send_ack_s1 <= s_tdata[8];
			sda_in_s1   <= s_tdata[9];
		end
	end

	// phase length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= i2cm_pkg::PHASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			phase_q <= cfg_data;
		end
	end

	// at most one sequencer step per tick
	always_comb begin
		active_op_d = active_op_q;
		step_d      = step_q;
		tick_d      = tick_q;
		bit_d       = bit_q;
		shift_d     = shift_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		dir_d       = dir_q;
		ack_d       = ack_q;
		rx_d        = rx_q;
		ack_send_d  = ack_send_q;
		execute     = 1'b0;
		done        = 1'b0;

		// command launch or wait countdown
		if (active_op_q == i2cm_pkg::OP_NONE) begin
			if (opcode_s1 inside {[i2cm_pkg::OP_START:i2cm_pkg::OP_RACK]}) begin
				active_op_d = opcode_s1;
				step_d      = 4'd0;
				bit_d       = 4'd0;
				if (opcode_s1 == i2cm_pkg::OP_WRITE) shift_d = wdata_s1;
				if (opcode_s1 == i2cm_pkg::OP_READ) ack_send_d = send_ack_s1;
				execute = 1'b1;
			end
		end else if (tick_q > 8'd1) begin
			tick_d = tick_q - 8'd1;
		end else begin
			execute = 1'b1;
		end

		step_cur = step_d;
		bit_inc  = bit_d + 4'd1;

		// pin actions of the current step
		if (execute) begin
			step_d = step_cur + 4'd1;
			case (active_op_d)
				i2cm_pkg::OP_START: begin
					if (step_cur == 4'd0) scl_d = 1'b1;
					else if (step_cur == 4'd1) sda_d = 1'b1;
					else begin
						sda_d = 1'b0;
						done  = 1'b1;
					end
				end
				i2cm_pkg::OP_STOP: begin
					if (step_cur == 4'd0) sda_d = 1'b0;
					else if (step_cur == 4'd1) scl_d = 1'b1;
					else begin
						sda_d = 1'b1;
						done  = 1'b1;
					end
				end
				i2cm_pkg::OP_RACK: begin
					if (step_cur == 4'd0) begin
						scl_d = 1'b0;
						dir_d = 1'b1;
					end else if (step_cur == 4'd1) begin
						scl_d = 1'b1;
					end else begin
						ack_d = sda_in_s1;
						scl_d = 1'b0;
						sda_d = 1'b1;
						dir_d = 1'b0;
						done  = 1'b1;
					end
				end
				i2cm_pkg::OP_WRITE: begin
					case (step_cur)
						4'd0: scl_d = 1'b0;
						4'd1: sda_d = |(shift_d & i2cm_pkg::MSB_MASK);
						4'd2: begin
							scl_d   = 1'b1;
							shift_d = {shift_d[6:0], 1'b0};
							bit_d   = bit_inc;
							// loop back for the next data bit, else go to the ack slot
							step_d  = (bit_inc < 4'(i2cm_pkg::BYTE_BITS)) ? 4'd0 : 4'd3;
						end
						4'd3: begin
							scl_d = 1'b0;
							dir_d = 1'b1;
						end
						4'd4, 4'd5: ;
						4'd6: scl_d = 1'b1;
						4'd7: begin
							ack_d = sda_in_s1;
							scl_d = 1'b0;
						end
						default: begin
							sda_d = 1'b1;
							dir_d = 1'b0;
							done  = 1'b1;
						end
					endcase
				end
				i2cm_pkg::OP_READ: begin
					case (step_cur)
						4'd0: begin
							scl_d   = 1'b0;
							dir_d   = 1'b1;
							shift_d = 8'd0;
							bit_d   = 4'd0;
						end
						4'd1: scl_d = 1'b1;
						4'd2: begin
							shift_d = {shift_d[6:0], sda_in_s1};
							bit_d   = bit_inc;
							scl_d   = 1'b0;
							if (bit_inc < 4'(i2cm_pkg::BYTE_BITS)) begin
								step_d = 4'd1;
							end else begin
								// drive ack low or release for nack
								sda_d = !ack_send_d;
								dir_d = 1'b0;
							end
						end
						4'd3: scl_d = 1'b1;
						default: begin
							scl_d = 1'b0;
							rx_d  = shift_d;
							done  = 1'b1;
						end
					endcase
				end
				default: done = 1'b1;
			endcase

			// end of command or reload of the wait
			if (done) begin
				active_op_d = i2cm_pkg::OP_NONE;
				step_d      = 4'd0;
				tick_d      = 8'd0;
			end else begin
				tick_d = (phase_q == 8'd0) ? 8'd1 : phase_q;
			end
		end
	end

	// sequencer state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_op_q <= i2cm_pkg::OP_NONE;
			step_q      <= 4'd0;
			tick_q      <= 8'd0;
			bit_q       <= 4'd0;
			shift_q     <= 8'd0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
			dir_q       <= 1'b0;
			ack_q       <= 1'b0;
			rx_q        <= 8'd0;
			ack_send_q  <= 1'b0;
		end else if (advance) begin
			active_op_q <= active_op_d;
			step_q      <= step_d;
			tick_q      <= tick_d;
			bit_q       <= bit_d;
			shift_q     <= shift_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
			dir_q       <= dir_d;
			ack_q       <= ack_d;
			rx_q        <= rx_d;
			ack_send_q  <= ack_send_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.scl_level    <= scl_d;
			out_q.sda_level    <= sda_d;
			out_q.sda_is_input <= dir_d;
			out_q.busy_res     <= (active_op_d != i2cm_pkg::OP_NONE);
			out_q.cmd_done     <= done;
			out_q.rx_byte      <= rx_d;
			out_q.ack_bit      <= ack_d;
		end
	end

endmodule
`default_nettype wire
